FILE: sv/wodo_pkg.sv
// Shared types, constants and helpers for the wheel odometry step.
// No dependencies; used by every module of the block.
package wodo_pkg;

    localparam int COUNT_BITS      = 16;
    localparam int TRIG_ITERATIONS = 24;

    localparam int MAG_W  = COUNT_BITS + 1;
    localparam int MA_W   = (MAG_W > 32) ? MAG_W : 32;
    localparam int PROD_W = MA_W + 32;
    localparam int DP_W   = MAG_W + 24;
    localparam int AHI_W  = DP_W - 32;
    localparam int HI_W   = AHI_W + 24;
    localparam int LO_W   = 40;
    localparam int TOT_W  = HI_W + 17;
    localparam int ITER_W = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;

    localparam int S_DATA_W = ((2 * COUNT_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = 128;
    localparam int CFG_W    = 24;

    localparam logic REG_DIST_PER_COUNT = 1'b0;
    localparam logic REG_INV_TRACK      = 1'b1;

    localparam logic [23:0] DIST_RESET = 24'd52690;
    localparam logic [23:0] INV_RESET  = 24'd327680;

    localparam logic signed [34:0] TWO_PI_Q24  = 35'sd105414357;
    localparam logic signed [34:0] PI_Q24      = 35'sd52707179;
    localparam logic signed [34:0] HALF_PI_Q24 = 35'sd26353589;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic [33:0]        NEG_OFFSET  = 34'd2213701497;

    typedef struct packed {
        logic signed [COUNT_BITS-1:0] dl;
        logic signed [COUNT_BITS-1:0] dr;
    } diff_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               clip;
    } sat_t;

    function automatic sat_t sat32(input logic neg, input logic [63:0] mag);
        sat_t r;
        begin
            r.clip = 1'b0;
            if (neg) begin
                if (mag > 64'd2147483648) begin
                    r.clip  = 1'b1;
                    r.value = 32'sh8000_0000;
                end else begin
                    r.value = -$signed(mag[31:0]);
                end
            end else begin
                if (mag > 64'd2147483647) begin
                    r.clip  = 1'b1;
                    r.value = 32'sh7FFF_FFFF;
                end else begin
                    r.value = $signed(mag[31:0]);
                end
            end
            return r;
        end
    endfunction

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  return 32'h3243F6A8;
            5'd1:  return 32'h1DAC6705;
            5'd2:  return 32'h0FADBAFC;
            5'd3:  return 32'h07F56EA6;
            5'd4:  return 32'h03FEAB76;
            5'd5:  return 32'h01FFD55B;
            5'd6:  return 32'h00FFFAAA;
            5'd7:  return 32'h007FFF55;
            5'd8:  return 32'h003FFFEA;
            5'd9:  return 32'h001FFFFD;
            5'd10: return 32'h000FFFFF;
            5'd11: return 32'h0007FFFF;
            5'd12: return 32'h0003FFFF;
            5'd13: return 32'h0001FFFF;
            5'd14: return 32'h0000FFFF;
            5'd15: return 32'h00007FFF;
            5'd16: return 32'h00003FFF;
            5'd17: return 32'h00001FFF;
            5'd18: return 32'h00000FFF;
            5'd19: return 32'h000007FF;
            5'd20: return 32'h000003FF;
            5'd21: return 32'h000001FF;
            5'd22: return 32'h000000FF;
            5'd23: return 32'h0000007F;
            5'd24: return 32'h0000003F;
            5'd25: return 32'h0000001F;
            5'd26: return 32'h0000000F;
            5'd27: return 32'h00000008;
            5'd28: return 32'h00000004;
            5'd29: return 32'h00000002;
            5'd30: return 32'h00000001;
            default: return 32'h00000000;
        endcase
    endfunction

endpackage

FILE: sv/wodo_front.sv
// Input side: tracks previous encoder counts, forms wrapped differences
// and queues them in a two-word buffer. Depends on wodo_pkg.
module wodo_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [wodo_pkg::COUNT_BITS-1:0]    left_count,
    input  logic [wodo_pkg::COUNT_BITS-1:0]    right_count,
    output logic                               q_valid,
    input  logic                               q_ready,
    output wodo_pkg::diff_t                    q_data
);

    logic [wodo_pkg::COUNT_BITS-1:0] last_left_reg, last_left_next;
    logic [wodo_pkg::COUNT_BITS-1:0] last_right_reg, last_right_next;
    logic                            seen_reg, seen_next;
    wodo_pkg::diff_t                 mem_reg [2];
    logic                            wr_ptr_reg, wr_ptr_next;
    logic                            rd_ptr_reg, rd_ptr_next;
    logic [1:0]                      count_reg, count_next;
    wodo_pkg::diff_t                 item;
    logic                            push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        item.dl = seen_reg ? $signed(left_count - last_left_reg) : '0;
        item.dr = seen_reg ? $signed(right_count - last_right_reg) : '0;
        last_left_next  = push ? left_count : last_left_reg;
        last_right_next = push ? right_count : last_right_reg;
        seen_next       = seen_reg | push;
        wr_ptr_next     = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next     = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next      = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_left_reg  <= '0;
            last_right_reg <= '0;
            seen_reg       <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= 2'd0;
        end else begin
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
            seen_reg       <= seen_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

FILE: sv/wodo_back.sv
// Compute side: shared multiplier sequencer for distances, heading and steps,
// angle reduction, iterative CORDIC and output register. Depends on wodo_pkg.
module wodo_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  wodo_pkg::diff_t        q_data,
    input  logic [23:0]            dist_per_count,
    input  logic [23:0]            inv_track,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            mean_distance,
    output logic [31:0]            heading_change,
    output logic [31:0]            step_x,
    output logic [31:0]            step_y,
    output logic                   clipped
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MEAN   = 4'd1;
    localparam logic [3:0] ST_HEADA  = 4'd2;
    localparam logic [3:0] ST_HEADB  = 4'd3;
    localparam logic [3:0] ST_HEADC  = 4'd4;
    localparam logic [3:0] ST_HEADD  = 4'd5;
    localparam logic [3:0] ST_REDUCE = 4'd6;
    localparam logic [3:0] ST_FOLD   = 4'd7;
    localparam logic [3:0] ST_CORDIC = 4'd8;
    localparam logic [3:0] ST_MULX   = 4'd9;
    localparam logic [3:0] ST_MULY   = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    localparam int MAG_W  = wodo_pkg::MAG_W;
    localparam int MA_W   = wodo_pkg::MA_W;
    localparam int PROD_W = wodo_pkg::PROD_W;

    logic [3:0]                    state_reg, state_next;
    logic                          sneg_reg, sneg_next, dneg_reg, dneg_next;
    logic [MAG_W-1:0]              smag_reg, smag_next, dmag_reg, dmag_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic [wodo_pkg::AHI_W-1:0]    ahi_reg, ahi_next;
    logic [wodo_pkg::LO_W-1:0]     lo_reg, lo_next;
    logic signed [31:0]            mean_reg, mean_next, head_reg, head_next;
    logic signed [31:0]            sx_reg, sx_next;
    logic                          clip_reg, clip_next;
    logic [33:0]                   v_reg, v_next;
    logic [2:0]                    k_reg, k_next;
    logic signed [33:0]            x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic                          flip_reg, flip_next;
    logic [wodo_pkg::ITER_W-1:0]   it_reg, it_next;
    logic                          ov_reg, ov_next;
    logic [31:0]                   o_mean_reg, o_head_reg, o_sx_reg, o_sy_reg;
    logic                          o_clip_reg;
    logic                          load_out;

    logic [MA_W-1:0]               mul_a;
    logic [31:0]                   mul_b;
    logic signed [MAG_W-1:0]       sum_w, dif_w;
    logic [wodo_pkg::TOT_W-1:0]    total;
    logic [63:0]                   head_mag;
    wodo_pkg::sat_t                sat_w;
    logic [31:0]                   mean_mag;
    logic                          cneg, sneg_t, xneg, yneg;
    logic [31:0]                   cmag, ymag;
    logic [33:0]                   sub_t;
    logic signed [34:0]            r_w;
    logic signed [33:0]            dx_w, dy_w, at_w;

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign mean_distance  = o_mean_reg;
    assign heading_change = o_head_reg;
    assign step_x         = o_sx_reg;
    assign step_y         = o_sy_reg;
    assign clipped        = o_clip_reg;
    assign load_out = (state_reg == ST_DONE) && (!ov_reg || out_ready);

    always_comb begin
        sum_w = MAG_W'(q_data.dl) + MAG_W'(q_data.dr);
        dif_w = MAG_W'(q_data.dr) - MAG_W'(q_data.dl);
        total = (wodo_pkg::TOT_W'(prod_reg[wodo_pkg::HI_W-1:0]) << 16)
              + wodo_pkg::TOT_W'(lo_reg);
        head_mag = (|total[wodo_pkg::TOT_W-1:32]) ? {64{1'b1}} : {32'd0, total[31:0]};
        mean_mag = mean_reg[31] ? 32'(-mean_reg) : 32'(mean_reg);
        xneg  = x_reg[33];
        yneg  = y_reg[33];
        cneg  = flip_reg ? (!xneg && (x_reg != '0)) : xneg;
        sneg_t = flip_reg ? (!yneg && (y_reg != '0)) : yneg;
        cmag  = xneg ? 32'(-x_reg) : 32'(x_reg);
        ymag  = yneg ? 32'(-y_reg) : 32'(y_reg);
        sub_t = 34'(wodo_pkg::TWO_PI_Q24) << k_reg;
        dx_w  = y_reg >>> it_reg;
        dy_w  = x_reg >>> it_reg;
        at_w  = $signed({2'b00, wodo_pkg::atan_q30(5'(it_reg))});
        r_w   = $signed({1'b0, v_reg});

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MEAN:  begin mul_a = MA_W'(smag_reg); mul_b = 32'(dist_per_count); end
            ST_HEADA: begin mul_a = MA_W'(dmag_reg); mul_b = 32'(dist_per_count); end
            ST_HEADB: begin mul_a = MA_W'(prod_reg[31:0]); mul_b = 32'(inv_track); end
            ST_HEADC: begin mul_a = MA_W'(ahi_reg); mul_b = 32'(inv_track); end
            ST_MULX:  begin mul_a = MA_W'(mean_mag); mul_b = cmag; end
            // sine product is held while the result waits in ST_DONE
            ST_MULY, ST_DONE: begin mul_a = MA_W'(mean_mag); mul_b = ymag; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

        state_next = state_reg;
        sneg_next = sneg_reg;  smag_next = smag_reg;
        dneg_next = dneg_reg;  dmag_next = dmag_reg;
        ahi_next  = ahi_reg;   lo_next   = lo_reg;
        mean_next = mean_reg;  head_next = head_reg;
        sx_next   = sx_reg;    clip_next = clip_reg;
        v_next    = v_reg;     k_next    = k_reg;
        x_next    = x_reg;     y_next    = y_reg;
        z_next    = z_reg;     flip_next = flip_reg;
        it_next   = it_reg;
        ov_next   = ov_reg & ~out_ready;
        sat_w     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    sneg_next  = sum_w[MAG_W-1];
                    smag_next  = sum_w[MAG_W-1] ? MAG_W'(-sum_w) : MAG_W'(sum_w);
                    dneg_next  = dif_w[MAG_W-1];
                    dmag_next  = dif_w[MAG_W-1] ? MAG_W'(-dif_w) : MAG_W'(dif_w);
                    clip_next  = 1'b0;
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:  state_next = ST_HEADA;
            ST_HEADA: begin
                sat_w      = wodo_pkg::sat32(sneg_reg,
                                 64'(prod_reg[wodo_pkg::DP_W-1:1]));
                mean_next  = sat_w.value;
                clip_next  = clip_reg | sat_w.clip;
                state_next = ST_HEADB;
            end
            ST_HEADB: begin
                ahi_next   = prod_reg[wodo_pkg::DP_W-1:32];
                state_next = ST_HEADC;
            end
            ST_HEADC: begin
                lo_next    = prod_reg[55:16];
                state_next = ST_HEADD;
            end
            ST_HEADD: begin
                sat_w      = wodo_pkg::sat32(dneg_reg, head_mag);
                head_next  = sat_w.value;
                clip_next  = clip_reg | sat_w.clip;
                v_next     = sat_w.value[31] ? 34'(sat_w.value) + wodo_pkg::NEG_OFFSET
                                             : 34'(sat_w.value);
                k_next     = 3'd4;
                state_next = ST_REDUCE;
            end
            ST_REDUCE: begin
                if (v_reg >= sub_t) begin
                    v_next = v_reg - sub_t;
                end
                k_next = k_reg - 3'd1;
                if (k_reg == 3'd0) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_w >= wodo_pkg::PI_Q24) begin
                    r_w = r_w - wodo_pkg::TWO_PI_Q24;
                end
                flip_next = 1'b0;
                if (r_w > wodo_pkg::HALF_PI_Q24) begin
                    r_w = r_w - wodo_pkg::PI_Q24;
                    flip_next = 1'b1;
                end else if (r_w < -wodo_pkg::HALF_PI_Q24) begin
                    r_w = r_w + wodo_pkg::PI_Q24;
                    flip_next = 1'b1;
                end
                z_next     = 34'(r_w) <<< 6;
                x_next     = wodo_pkg::GAIN_Q30;
                y_next     = '0;
                it_next    = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (!z_reg[33]) begin
                    x_next = x_reg - dx_w;
                    y_next = y_reg + dy_w;
                    z_next = z_reg - at_w;
                end else begin
                    x_next = x_reg + dx_w;
                    y_next = y_reg - dy_w;
                    z_next = z_reg + at_w;
                end
                it_next = it_reg + 1'b1;
                if (it_reg == wodo_pkg::ITER_W'(wodo_pkg::TRIG_ITERATIONS - 1)) begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX:  state_next = ST_MULY;
            ST_MULY: begin
                sat_w      = wodo_pkg::sat32(mean_reg[31] != cneg, 64'(prod_reg[63:30]));
                sx_next    = sat_w.value;
                clip_next  = clip_reg | sat_w.clip;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                sat_w = wodo_pkg::sat32(mean_reg[31] != sneg_t, 64'(prod_reg[63:30]));
                if (load_out) begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        sneg_reg <= sneg_next;  smag_reg <= smag_next;
        dneg_reg <= dneg_next;  dmag_reg <= dmag_next;
        prod_reg <= prod_next;
        ahi_reg  <= ahi_next;   lo_reg   <= lo_next;
        mean_reg <= mean_next;  head_reg <= head_next;
        sx_reg   <= sx_next;    clip_reg <= clip_next;
        v_reg    <= v_next;     k_reg    <= k_next;
        x_reg    <= x_next;     y_reg    <= y_next;
        z_reg    <= z_next;     flip_reg <= flip_next;
        it_reg   <= it_next;
        if (load_out) begin
            o_mean_reg <= mean_reg;
            o_head_reg <= head_reg;
            o_sx_reg   <= sx_reg;
            o_sy_reg   <= sat_w.value;
            o_clip_reg <= clip_reg | sat_w.clip;
        end
    end

endmodule

FILE: sv/wheel_odometry_step.sv
// Wheel odometry step: encoder counts in, distance, heading and step out.
// The compute side takes a new word only once it is done with the last;
// its pace is set by the 24-step CORDIC loop and the shared multiplier
// sequence. The input buffer takes two words ahead.
// Reset (aresetn, synchronous): counts and first-sample flag cleared,
// registers return to defaults, buffer and output register emptied.
module wheel_odometry_step (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // left_count, right_count
    input  logic [wodo_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mean_distance, heading_change, step_x, step_y
    output logic [wodo_pkg::M_DATA_W-1:0]   m_tdata,
    // clipped
    output logic                            m_tuser,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_addr,
    input  logic [wodo_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int CB = wodo_pkg::COUNT_BITS;

    logic [23:0]     dist_reg, inv_reg;
    logic            q_valid, q_ready;
    wodo_pkg::diff_t q_data;
    logic [31:0]     mean_w, head_w, sx_w, sy_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg <= wodo_pkg::DIST_RESET;
            inv_reg  <= wodo_pkg::INV_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                wodo_pkg::REG_DIST_PER_COUNT: dist_reg <= cfg_wdata;
                wodo_pkg::REG_INV_TRACK:      inv_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    wodo_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .left_count  (s_tdata[CB-1:0]),
        .right_count (s_tdata[2*CB-1:CB]),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data)
    );

    wodo_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_data         (q_data),
        .dist_per_count (dist_reg),
        .inv_track      (inv_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .mean_distance  (mean_w),
        .heading_change (head_w),
        .step_x         (sx_w),
        .step_y         (sy_w),
        .clipped        (m_tuser)
    );

    assign m_tdata = {sy_w, sx_w, head_w, mean_w};

endmodule
